// File: rtl/alarm_latch_with_history_defines.svh
// Assertion macros shared by the alarm latch modules.
// ALH_ASSERT checks a property on every rising clock edge outside reset.
// ALH_ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef ALARM_LATCH_WITH_HISTORY_DEFINES_SVH
`define ALARM_LATCH_WITH_HISTORY_DEFINES_SVH

`ifndef SYNTHESIS
`define ALH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ALH_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ALH_ASSERT(lbl, clk, rstn, prop, msg)
`define ALH_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// File: rtl/alh_pkg.sv
`timescale 1ns / 1ps

package alh_pkg;

  localparam int OpW    = 3;
  localparam int IdW    = 4;
  localparam int TimeW  = 32;
  localparam int CodeW  = 16;
  localparam int HidxW  = 3;
  localparam int MaskW  = 16;

  localparam int NumAlarmsDef    = 16;
  localparam int HistoryDepthDef = 8;

  typedef enum logic [OpW-1:0] {
    OP_RAISE        = 3'd0,
    OP_RESET_TRIG   = 3'd1,
    OP_CHECK        = 3'd2,
    OP_CLEAR_RECOV  = 3'd3,
    OP_CLEAR_HIST   = 3'd4,
    OP_READ_HIST    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic cfg_we;
  } ctrl_cmd_t;

  localparam logic [IdW-1:0] ID_OVERTEMP   = 4'd1;
  localparam logic [IdW-1:0] ID_OVERCURR   = 4'd2;
  localparam logic [IdW-1:0] ID_UNDERVOLT  = 4'd3;
  localparam logic [IdW-1:0] ID_COMM_LOST  = 4'd4;
  localparam logic [IdW-1:0] ID_COMM_CRC   = 4'd5;

  localparam logic [CodeW-1:0] CODE_OVERTEMP  = 16'd106;
  localparam logic [CodeW-1:0] CODE_OVERCURR  = 16'd107;
  localparam logic [CodeW-1:0] CODE_UNDERVOLT = 16'd521;
  localparam logic [CodeW-1:0] CODE_COMM_LOST = 16'd800;
  localparam logic [CodeW-1:0] CODE_COMM_CRC  = 16'd801;
  localparam logic [CodeW-1:0] CODE_NONE      = 16'd0;

  function automatic logic [CodeW-1:0] code_of(input logic [IdW-1:0] id);
    logic [CodeW-1:0] code;
    unique case (id)
      ID_OVERTEMP:  code = CODE_OVERTEMP;
      ID_OVERCURR:  code = CODE_OVERCURR;
      ID_UNDERVOLT: code = CODE_UNDERVOLT;
      ID_COMM_LOST: code = CODE_COMM_LOST;
      ID_COMM_CRC:  code = CODE_COMM_CRC;
      default:      code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/alh_ctrl.sv
`timescale 1ns / 1ps
`include "alarm_latch_with_history_defines.svh"

module alh_ctrl
  import alh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      cfg_valid_i,
  output logic      busy_o,
  output logic      done_o,
  output logic      cfg_ready_o,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = start_i ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o         = (state_q == ST_EXEC);
    done_o         = (state_q == ST_RESP);
    cfg_ready_o    = (state_q != ST_EXEC);
    cmd_o.capture  = start_i && (state_q != ST_EXEC);
    cmd_o.exec     = (state_q == ST_EXEC);
    cmd_o.cfg_we   = cfg_valid_i && (state_q != ST_EXEC);
  end

  `ALH_ASSERT(a_accept_goes_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "accepted request did not start execution")
  `ALH_ASSERT(a_done_after_exec, clk_i, rst_ni, done_o |-> $past(cmd_o.exec), "result strobe without a preceding execute cycle")
  `ALH_ASSERT_NEVER(a_busy_and_done, clk_i, rst_ni, busy_o && done_o, "busy and done high together")

endmodule

// File: rtl/alh_datapath.sv
`timescale 1ns / 1ps
`include "alarm_latch_with_history_defines.svh"

module alh_datapath
  import alh_pkg::*;
#(
  parameter int NUM_ALARMS    = NumAlarmsDef,
  parameter int HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic [OpW-1:0]   op_i,
  input  logic [IdW-1:0]   alarm_id_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic [HidxW-1:0] history_index_i,
  input  logic [MaskW-1:0] cfg_wdata_i,
  output logic             is_active_o,
  output logic             any_active_o,
  output logic             newly_latched_o,
  output logic [CodeW-1:0] last_code_o,
  output logic [CodeW-1:0] hist_code_o,
  output logic [TimeW-1:0] hist_time_o
);

  // Captured request.
  op_e              op_q;
  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] now_q;
  logic [HidxW-1:0] hidx_q;

  // Alarm state.
  logic [MaskW-1:0]      mask_q;
  logic [NUM_ALARMS-1:0] trig_q, trig_d;
  logic [NUM_ALARMS-1:0] act_q, act_d;
  logic [CodeW-1:0]      latest_q, latest_d;
  logic [CodeW-1:0]      hcode_q [HISTORY_DEPTH];
  logic [CodeW-1:0]      hcode_d [HISTORY_DEPTH];
  logic [TimeW-1:0]      htime_q [HISTORY_DEPTH];
  logic [TimeW-1:0]      htime_d [HISTORY_DEPTH];

  // Result registers.
  logic             res_is_act_q, res_is_act_d;
  logic             res_any_q, res_any_d;
  logic             res_newly_q, res_newly_d;
  logic [CodeW-1:0] res_hcode_q, res_hcode_d;
  logic [TimeW-1:0] res_htime_q, res_htime_d;

  logic                  id_valid;
  logic [NUM_ALARMS-1:0] id_onehot;
  logic                  id_active;
  logic                  raise_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(op_i);
      id_q   <= alarm_id_i;
      now_q  <= now_ms_i;
      hidx_q <= history_index_i;
    end
  end

  always_comb begin
    id_valid = (id_q != '0) && (32'(id_q) < NUM_ALARMS);
    for (int k = 0; k < NUM_ALARMS; k++) begin
      id_onehot[k] = id_valid && (32'(id_q) == k);
    end
    id_active = |(act_q & id_onehot);
    raise_new = (op_q == OP_RAISE) && id_valid && !id_active && !mask_q[id_q];
  end

  always_comb begin
    trig_d       = trig_q;
    act_d        = act_q;
    latest_d     = latest_q;
    hcode_d      = hcode_q;
    htime_d      = htime_q;
    res_is_act_d = 1'b0;
    res_newly_d  = 1'b0;
    res_hcode_d  = '0;
    res_htime_d  = '0;
    unique case (op_q)
      OP_RAISE: begin
        trig_d = trig_q | id_onehot;
        if (raise_new) begin
          act_d       = act_q | id_onehot;
          latest_d    = code_of(id_q);
          res_newly_d = 1'b1;
          for (int k = 1; k < HISTORY_DEPTH; k++) begin
            hcode_d[k] = hcode_q[k-1];
            htime_d[k] = htime_q[k-1];
          end
          hcode_d[0] = latest_d;
          htime_d[0] = now_q;
        end
      end
      OP_RESET_TRIG: begin
        trig_d = trig_q & ~id_onehot;
      end
      OP_CHECK: begin
        res_is_act_d = (id_q == '0) ? (|act_q) : id_active;
      end
      OP_CLEAR_RECOV: begin
        act_d = act_q & trig_q;
      end
      OP_CLEAR_HIST: begin
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          hcode_d[k] = '0;
          htime_d[k] = '0;
        end
      end
      OP_READ_HIST: begin
        // An index past the last entry matches nothing and reads as zero.
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          if (32'(hidx_q) == k) begin
            res_hcode_d = hcode_q[k];
            res_htime_d = htime_q[k];
          end
        end
      end
      default: begin
      end
    endcase
    res_any_d = |act_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      trig_q       <= '0;
      act_q        <= '0;
      latest_q     <= '0;
      res_is_act_q <= 1'b0;
      res_any_q    <= 1'b0;
      res_newly_q  <= 1'b0;
      res_hcode_q  <= '0;
      res_htime_q  <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hcode_q[k] <= '0;
        htime_q[k] <= '0;
      end
    end else begin
      if (cmd_i.cfg_we) begin
        mask_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        trig_q       <= trig_d;
        act_q        <= act_d;
        latest_q     <= latest_d;
        hcode_q      <= hcode_d;
        htime_q      <= htime_d;
        res_is_act_q <= res_is_act_d;
        res_any_q    <= res_any_d;
        res_newly_q  <= res_newly_d;
        res_hcode_q  <= res_hcode_d;
        res_htime_q  <= res_htime_d;
      end
    end
  end

  assign is_active_o     = res_is_act_q;
  assign any_active_o    = res_any_q;
  assign newly_latched_o = res_newly_q;
  assign last_code_o     = latest_q;
  assign hist_code_o     = res_hcode_q;
  assign hist_time_o     = res_htime_q;

  `ALH_ASSERT(a_newly_sets_any, clk_i, rst_ni, res_newly_q |-> res_any_q, "new latch reported with no active alarm")
  `ALH_ASSERT(a_newly_heads_history, clk_i, rst_ni, res_newly_q |-> (hcode_q[0] == latest_q), "newest history entry differs from latest code")

endmodule

// File: rtl/alarm_latch_with_history.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+--------------------------------------
// request   | in        | start, busy                    | op_i, alarm_id_i, now_ms_i,
//           |           |                                | history_index_i
// result    | out       | done_o (one-cycle strobe)      | is_active_o, any_active_o,
//           |           |                                | newly_latched_o, last_code_o,
//           |           |                                | hist_code_o, hist_time_o
// config    | in        | cfg_valid_i, cfg_ready_o       | cfg_wdata_i (alarm mask)
//
// A request is taken at a clock edge where start is high and busy is low.
// Each request is handled in order: the operands are captured, then the
// datapath updates the alarm state and history and registers the result.
// The result is on the ports with done_o high in the cycle after execution; a
// new request may be taken in that same cycle. The receiver cannot stall, so
// results are never held back. Reset is asynchronous and active low and
// clears mask, alarm state, latest code and the whole history at once; no
// clearing pass is needed.

module alarm_latch_with_history
  import alh_pkg::*;
#(
  parameter int NUM_ALARMS    = NumAlarmsDef,
  parameter int HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Request channel.
  input  logic             start,
  output logic             busy,
  input  logic [OpW-1:0]   op_i,
  input  logic [IdW-1:0]   alarm_id_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic [HidxW-1:0] history_index_i,
  // Configuration channel: the alarm mask register.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [MaskW-1:0] cfg_wdata_i,
  // Result channel.
  output logic             done_o,
  output logic             is_active_o,
  output logic             any_active_o,
  output logic             newly_latched_o,
  output logic [CodeW-1:0] last_code_o,
  output logic [CodeW-1:0] hist_code_o,
  output logic [TimeW-1:0] hist_time_o
);

  // The controller sequences capture and execute; the datapath holds all
  // alarm state and never decides on its own when to update.
  ctrl_cmd_t cmd;

  alh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cfg_valid_i (cfg_valid_i),
    .busy_o      (busy),
    .done_o      (done_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // A raise sets the trigger bit; when the alarm is neither active nor masked
  // it is also latched, its code becomes the latest code, and the code and
  // timestamp are shifted into the history, dropping the oldest entry.
  alh_datapath #(
    .NUM_ALARMS    (NUM_ALARMS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .alarm_id_i      (alarm_id_i),
    .now_ms_i        (now_ms_i),
    .history_index_i (history_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .is_active_o     (is_active_o),
    .any_active_o    (any_active_o),
    .newly_latched_o (newly_latched_o),
    .last_code_o     (last_code_o),
    .hist_code_o     (hist_code_o),
    .hist_time_o     (hist_time_o)
  );

endmodule
